FILE: sv/rih_pkg.sv
package rih_pkg;

	localparam int NUM_BLOCKS = 65536;
	localparam int BLK_W = $clog2(NUM_BLOCKS);
	localparam int HIST_BINS = 4096;
	localparam int BIN_W = $clog2(HIST_BINS);
	localparam int MAX_LENGTH = 256;
	localparam int LEN_W = 9;
	localparam int COUNT_W = 32;
	localparam int TS_W = 64;
	localparam int DIV_W = 32;
	localparam int STEP_W = $clog2(BIN_W + 1);
	localparam logic [DIV_W-1:0] RESET_DIVISOR = DIV_W'(10000000);

	typedef logic [1:0] blk_kind_t;
	localparam blk_kind_t KIND_NONE = 2'd0;
	localparam blk_kind_t KIND_READ = 2'd1;
	localparam blk_kind_t KIND_WRITE = 2'd2;

	typedef struct packed {
		logic start;
		logic [TS_W-1:0] now;
		logic [TS_W-1:0] last;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [BIN_W-1:0] bin;
	} div_rsp_t;

endpackage

FILE: sv/rih_div.sv
module rih_div (
	input  logic clk,
	input  logic arst_n,
	input  rih_pkg::div_req_t req,
	output rih_pkg::div_rsp_t rsp
);

	localparam int REM_W = rih_pkg::DIV_W + rih_pkg::BIN_W;
	localparam int DSH_W = rih_pkg::DIV_W + rih_pkg::BIN_W - 1;

	logic busy_q;
	logic done_q;
	logic [rih_pkg::STEP_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [rih_pkg::BIN_W-1:0] quo_q;
	logic [rih_pkg::TS_W-1:0] diff;
	logic sat;
	logic ge;

	assign diff = req.now - req.last;
	assign sat = (req.now < req.last) || (req.divisor == '0) ||
		(diff >= rih_pkg::TS_W'({req.divisor, rih_pkg::BIN_W'(0)}));
	assign ge = rem_q >= {1'b0, dsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= rih_pkg::STEP_W'(rih_pkg::BIN_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rih_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= sat ? '1 : '0;
			rem_q <= diff[REM_W-1:0];
			dsh_q <= {req.divisor, (rih_pkg::BIN_W-1)'(0)};
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - {1'b0, dsh_q};
			quo_q <= {quo_q[rih_pkg::BIN_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.bin = quo_q;

endmodule

FILE: sv/block_reuse_interval_histogram.sv
// Bin read: ST_BINRD, then ST_DONE. Dropped or zero-length request: ST_DONE at once.
// Storage request: per block ST_READ, ST_CHECK; a block with a prior read then waits
// in ST_DIVW (12-step shared divider; at once if the interval falls in the last bin),
// then a histogram read-modify-write; the first block off the table ends the walk.
// Result sits in an output register; the next item is accepted while it waits.
// After reset a clearing pass zeroes kinds and histograms; divisor resets to 10000000.
module block_reuse_interval_histogram (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic kind,
	input  logic [63:0] req_timestamp,
	input  logic req_is_write,
	input  logic [15:0] req_offset,
	input  logic [8:0] req_length,
	input  logic hist_select,
	input  logic [11:0] bin_index,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [8:0] rar_hits,
	output logic [8:0] war_hits,
	output logic dropped,
	output logic out_of_range,
	output logic [31:0] bin_count,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_READ   = 9'b000000100,
		ST_CHECK  = 9'b000001000,
		ST_DIVW   = 9'b000010000,
		ST_HREAD  = 9'b000100000,
		ST_HWRITE = 9'b001000000,
		ST_BINRD  = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [rih_pkg::DIV_W-1:0] divisor_q;
	logic [rih_pkg::TS_W-1:0] prev_q;
	logic seen_q;
	logic [rih_pkg::BLK_W-1:0] clr_q;
	logic [rih_pkg::TS_W-1:0] ts_q;
	logic wr_q;
	logic sel_q;
	logic isbin_q;
	logic drop_q;
	logic oor_q;
	logic [rih_pkg::BLK_W:0] blk_q;
	logic [rih_pkg::LEN_W-1:0] left_q;
	logic [rih_pkg::LEN_W-1:0] rar_q;
	logic [rih_pkg::LEN_W-1:0] war_q;
	logic [rih_pkg::BIN_W-1:0] bin_q;

	rih_pkg::blk_kind_t kind_mem [rih_pkg::NUM_BLOCKS];
	logic [rih_pkg::TS_W-1:0] time_mem [rih_pkg::NUM_BLOCKS];
	logic [rih_pkg::COUNT_W-1:0] rar_mem [rih_pkg::HIST_BINS];
	logic [rih_pkg::COUNT_W-1:0] war_mem [rih_pkg::HIST_BINS];
	rih_pkg::blk_kind_t kind_rd_q;
	logic [rih_pkg::TS_W-1:0] time_rd_q;
	logic [rih_pkg::COUNT_W-1:0] rar_rd_q;
	logic [rih_pkg::COUNT_W-1:0] war_rd_q;

	logic rsp_valid_q;
	logic [8:0] rar_out_q;
	logic [8:0] war_out_q;
	logic drop_out_q;
	logic oor_out_q;
	logic [31:0] count_out_q;

	rih_pkg::div_req_t div_req;
	rih_pkg::div_rsp_t div_rsp;

	logic accept;
	logic load_out;
	logic [rih_pkg::LEN_W-1:0] len_clamped;
	logic [rih_pkg::BIN_W-1:0] hist_addr;
	logic hist_rd_en;
	logic [rih_pkg::COUNT_W-1:0] hist_cur;
	logic [rih_pkg::COUNT_W-1:0] hist_inc;
	logic [rih_pkg::COUNT_W-1:0] sel_cnt;
	logic last_blk;

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign load_out = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign len_clamped = (req_length > rih_pkg::LEN_W'(rih_pkg::MAX_LENGTH)) ?
		rih_pkg::LEN_W'(rih_pkg::MAX_LENGTH) : req_length;
	assign last_blk = (left_q == rih_pkg::LEN_W'(1));

	assign hist_rd_en = accept || div_rsp.done;
	assign hist_addr = accept ? bin_index : div_rsp.bin;
	assign hist_cur = wr_q ? war_rd_q : rar_rd_q;
	assign hist_inc = (hist_cur == '1) ? hist_cur : hist_cur + 1'b1;
	assign sel_cnt = sel_q ? war_rd_q : rar_rd_q;

	assign div_req.start = (state_q == ST_CHECK) && (kind_rd_q == rih_pkg::KIND_READ);
	assign div_req.now = ts_q;
	assign div_req.last = time_rd_q;
	assign div_req.divisor = divisor_q;

	rih_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			divisor_q <= rih_pkg::RESET_DIVISOR;
			prev_q <= '0;
			seen_q <= 1'b0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) divisor_q <= cfg_data;
			if (load_out) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (kind) begin
							state_q <= ST_BINRD;
						end else if (seen_q && (req_timestamp < prev_q)) begin
							state_q <= ST_DONE;
						end else begin
							seen_q <= 1'b1;
							prev_q <= req_timestamp;
							state_q <= (len_clamped == '0) ? ST_DONE : ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= blk_q[rih_pkg::BLK_W] ? ST_DONE : ST_CHECK;
				end
				ST_CHECK: begin
					if (kind_rd_q == rih_pkg::KIND_READ) state_q <= ST_DIVW;
					else state_q <= last_blk ? ST_DONE : ST_READ;
				end
				ST_DIVW: begin
					if (div_rsp.done) state_q <= ST_HREAD;
				end
				ST_HREAD: state_q <= ST_HWRITE;
				ST_HWRITE: state_q <= last_blk ? ST_DONE : ST_READ;
				ST_BINRD: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q <= req_timestamp;
			wr_q <= req_is_write;
			sel_q <= hist_select;
			isbin_q <= kind;
			drop_q <= !kind && seen_q && (req_timestamp < prev_q);
			oor_q <= 1'b0;
			blk_q <= {1'b0, req_offset};
			left_q <= len_clamped;
			rar_q <= '0;
			war_q <= '0;
		end
		if (state_q == ST_READ && blk_q[rih_pkg::BLK_W]) oor_q <= 1'b1;
		if ((state_q == ST_CHECK && kind_rd_q != rih_pkg::KIND_READ) ||
			state_q == ST_HWRITE) begin
			blk_q <= blk_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
		if (state_q == ST_HWRITE) begin
			if (wr_q) war_q <= war_q + 1'b1;
			else rar_q <= rar_q + 1'b1;
		end
		if (div_rsp.done) bin_q <= div_rsp.bin;
	end

	// block tables
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			kind_mem[clr_q] <= rih_pkg::KIND_NONE;
		end else if (state_q == ST_CHECK) begin
			kind_mem[blk_q[rih_pkg::BLK_W-1:0]] <=
				wr_q ? rih_pkg::KIND_WRITE : rih_pkg::KIND_READ;
		end
		if (state_q == ST_READ) kind_rd_q <= kind_mem[blk_q[rih_pkg::BLK_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) time_mem[blk_q[rih_pkg::BLK_W-1:0]] <= ts_q;
		if (state_q == ST_READ) time_rd_q <= time_mem[blk_q[rih_pkg::BLK_W-1:0]];
	end

	// histograms
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			rar_mem[clr_q[rih_pkg::BIN_W-1:0]] <= '0;
		end else if (state_q == ST_HWRITE && !wr_q) begin
			rar_mem[bin_q] <= hist_inc;
		end
		if (hist_rd_en) rar_rd_q <= rar_mem[hist_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			war_mem[clr_q[rih_pkg::BIN_W-1:0]] <= '0;
		end else if (state_q == ST_HWRITE && wr_q) begin
			war_mem[bin_q] <= hist_inc;
		end
		if (hist_rd_en) war_rd_q <= war_mem[hist_addr];
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rar_out_q <= isbin_q ? '0 : rar_q;
			war_out_q <= isbin_q ? '0 : war_q;
			drop_out_q <= !isbin_q && drop_q;
			oor_out_q <= !isbin_q && oor_q;
			count_out_q <= isbin_q ? 32'(sel_cnt) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rar_hits = rar_out_q;
	assign war_hits = war_out_q;
	assign dropped = drop_out_q;
	assign out_of_range = oor_out_q;
	assign bin_count = count_out_q;

endmodule

FILE: test/tb_block_reuse_interval_histogram.sv
`timescale 1ns / 100ps

module tb_block_reuse_interval_histogram;

	localparam int WATCHDOG_LIMIT = 250000;
	localparam int HOLD_CYCLES = 3000;
	localparam int ITEMS_PER_PHASE = 250;

	typedef enum bit {ITEM_ACCESS = 1'b0, ITEM_BIN_READ = 1'b1} item_kind_e;
	typedef enum bit {HIST_RAR = 1'b0, HIST_WAR = 1'b1} hist_sel_e;

	typedef struct {
		item_kind_e kind;
		logic [rih_pkg::TS_W-1:0] ts;
		logic is_write;
		logic [15:0] offset;
		logic [rih_pkg::LEN_W-1:0] length;
		hist_sel_e sel;
		logic [rih_pkg::BIN_W-1:0] bin_index;
	} access_item_t;

	typedef struct {
		logic [8:0] rar;
		logic [8:0] war;
		logic drop;
		logic oor;
		logic [31:0] count;
	} outcome_t;

	class reuse_scoreboard;
		rih_pkg::blk_kind_t blk_kind[rih_pkg::NUM_BLOCKS];
		logic [rih_pkg::TS_W-1:0] blk_time[rih_pkg::NUM_BLOCKS];
		logic [rih_pkg::COUNT_W-1:0] rar_hist[rih_pkg::HIST_BINS];
		logic [rih_pkg::COUNT_W-1:0] war_hist[rih_pkg::HIST_BINS];
		logic [rih_pkg::TS_W-1:0] prev_ts;
		bit seen;
		logic [rih_pkg::DIV_W-1:0] divisor;
		outcome_t pending_outcomes[$];
		int n_rar, n_war, n_drop, n_oor, n_bin_reads, n_access;

		function new();
			foreach (blk_kind[i]) blk_kind[i] = rih_pkg::KIND_NONE;
			foreach (rar_hist[i]) begin
				rar_hist[i] = '0;
				war_hist[i] = '0;
			end
			prev_ts = '0;
			seen = 0;
			divisor = rih_pkg::RESET_DIVISOR;
		endfunction

		function int unsigned interval_bin(logic [rih_pkg::TS_W-1:0] last,
			logic [rih_pkg::TS_W-1:0] now);
			logic [rih_pkg::TS_W-1:0] q;
			if (now < last || divisor == 0)
				return rih_pkg::HIST_BINS - 1;
			q = (now - last) / {32'b0, divisor};
			if (q >= rih_pkg::HIST_BINS)
				return rih_pkg::HIST_BINS - 1;
			return int'(q);
		endfunction

		function void note_input(access_item_t it);
			outcome_t o;
			int len;
			int blk;
			int unsigned b;
			o = '{default: '0};
			if (it.kind == ITEM_BIN_READ) begin
				n_bin_reads++;
				if (it.bin_index < rih_pkg::HIST_BINS)
					o.count = (it.sel == HIST_WAR) ? war_hist[it.bin_index] :
						rar_hist[it.bin_index];
			end else if (seen && it.ts < prev_ts) begin
				o.drop = 1;
				n_drop++;
			end else begin
				n_access++;
				seen = 1;
				prev_ts = it.ts;
				len = (it.length > rih_pkg::MAX_LENGTH) ? rih_pkg::MAX_LENGTH :
					int'(it.length);
				for (int i = 0; i < len; i++) begin
					blk = int'(it.offset) + i;
					if (blk >= rih_pkg::NUM_BLOCKS) begin
						o.oor = 1;
						continue;
					end
					if (blk_kind[blk] == rih_pkg::KIND_READ) begin
						b = interval_bin(blk_time[blk], it.ts);
						if (it.is_write) begin
							if (war_hist[b] != '1) war_hist[b]++;
							o.war++;
						end else begin
							if (rar_hist[b] != '1) rar_hist[b]++;
							o.rar++;
						end
					end
					blk_kind[blk] = it.is_write ? rih_pkg::KIND_WRITE : rih_pkg::KIND_READ;
					blk_time[blk] = it.ts;
				end
				n_rar += o.rar;
				n_war += o.war;
				n_oor += o.oor;
			end
			pending_outcomes.push_back(o);
		endfunction

		// empty string when the beat matches the oldest expectation
		function string check_result(outcome_t got);
			outcome_t exp_o;
			string msg;
			exp_o = pending_outcomes.pop_front();
			msg = "";
			if (got.rar !== exp_o.rar)
				msg = {msg, $sformatf(" rar_hits %0d/%0d", got.rar, exp_o.rar)};
			if (got.war !== exp_o.war)
				msg = {msg, $sformatf(" war_hits %0d/%0d", got.war, exp_o.war)};
			if (got.drop !== exp_o.drop)
				msg = {msg, $sformatf(" dropped %0b/%0b", got.drop, exp_o.drop)};
			if (got.oor !== exp_o.oor)
				msg = {msg, $sformatf(" out_of_range %0b/%0b", got.oor, exp_o.oor)};
			if (got.count !== exp_o.count)
				msg = {msg, $sformatf(" bin_count %0d/%0d", got.count, exp_o.count)};
			return msg;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic kind;
	logic [63:0] req_timestamp;
	logic req_is_write;
	logic [15:0] req_offset;
	logic [8:0] req_length;
	logic hist_select;
	logic [11:0] bin_index;
	logic rsp_valid;
	logic rsp_stall;
	logic [8:0] rar_hits;
	logic [8:0] war_hits;
	logic dropped;
	logic out_of_range;
	logic [31:0] bin_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] cfg_data;

	reuse_scoreboard sb;
	int errors;
	int tx_idle;
	int rx_idle;
	int hold_asks;
	int hold_served;
	int hold_left;
	int quiet_cycles;
	int results_seen;

	block_reuse_interval_histogram u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.req_timestamp(req_timestamp),
		.req_is_write(req_is_write),
		.req_offset(req_offset),
		.req_length(req_length),
		.hist_select(hist_select),
		.bin_index(bin_index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rar_hits(rar_hits),
		.war_hits(war_hits),
		.dropped(dropped),
		.out_of_range(out_of_range),
		.bin_count(bin_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(string msg);
		errors++;
		$display("[%0t] mismatch:%s", $realtime, msg);
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		string msg;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			got = '{rar: rar_hits, war: war_hits, drop: dropped, oor: out_of_range,
				count: bin_count};
			if (sb.pending_outcomes.size() == 0) begin
				report(" result beat with nothing expected");
			end else begin
				msg = sb.check_result(got);
				if (msg != "") report(msg);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(access_item_t it);
		if ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		kind <= it.kind;
		req_timestamp <= it.ts;
		req_is_write <= it.is_write;
		req_offset <= it.offset;
		req_length <= it.length;
		hist_select <= it.sel;
		bin_index <= it.bin_index;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_input(it);
	endtask

	function automatic access_item_t noise_item();
		access_item_t it;
		it.kind = ITEM_ACCESS;
		it.ts = {$urandom, $urandom};
		it.is_write = 1'($urandom_range(1));
		it.offset = 16'($urandom);
		it.length = rih_pkg::LEN_W'($urandom);
		it.sel = hist_sel_e'($urandom_range(1));
		it.bin_index = rih_pkg::BIN_W'($urandom);
		return it;
	endfunction

	task automatic access(logic [63:0] ts, logic wr, logic [15:0] off, logic [8:0] len);
		access_item_t it;
		it = noise_item();
		it.ts = ts;
		it.is_write = wr;
		it.offset = off;
		it.length = len;
		send(it);
	endtask

	task automatic read_bin(hist_sel_e sel, logic [11:0] idx);
		access_item_t it;
		it = noise_item();
		it.kind = ITEM_BIN_READ;
		it.sel = sel;
		it.bin_index = idx;
		send(it);
	endtask

	task automatic write_divisor(logic [31:0] value);
		req_valid <= 1'b0;
		while (sb.pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.divisor = value;
	endtask

	function automatic access_item_t random_item();
		access_item_t it;
		logic [63:0] delta;
		it = noise_item();
		if ($urandom_range(99) < 8) begin
			it.kind = ITEM_BIN_READ;
			if ($urandom_range(1)) it.bin_index = rih_pkg::BIN_W'($urandom_range(24));
			return it;
		end
		case ($urandom_range(3))
			0: delta = 0;
			1: delta = 64'(sb.divisor) * $urandom_range(20) + $urandom_range(999);
			2: delta = {32'b0, $urandom};
			default: delta = 64'($urandom) << $urandom_range(12);
		endcase
		case ($urandom_range(19))
			0: ;    // full random timestamp
			1: it.ts = sb.prev_ts - $urandom_range(1, 1000);
			default: it.ts = sb.prev_ts + delta;
		endcase
		case ($urandom_range(9))
			0: it.offset = 16'($urandom_range(65535, 65500));
			1, 2: ;
			default: it.offset = 16'($urandom_range(127));
		endcase
		case ($urandom_range(19))
			0: ;
			1, 2, 3: it.length = rih_pkg::LEN_W'($urandom_range(64, 9));
			default: it.length = rih_pkg::LEN_W'($urandom_range(8));
		endcase
		return it;
	endfunction

	initial begin
		logic [31:0] divisors[6];
		sb = new();
		errors = 0;
		tx_idle = 0;
		rx_idle = 0;
		hold_asks = 0;
		hold_served = 0;
		hold_left = 0;
		quiet_cycles = 0;
		results_seen = 0;
		arst_n = 1'b0;
		req_valid <= 1'b0;
		rsp_stall <= 1'b0;
		kind <= 1'b0;
		req_timestamp <= '0;
		req_is_write <= 1'b0;
		req_offset <= '0;
		req_length <= '0;
		hist_select <= 1'b0;
		bin_index <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default divisor of 10000000 ticks per bin
		read_bin(HIST_RAR, 12'd0);
		access(64'd0, 1'b0, 16'd0, 9'd4);
		access(64'd50000000, 1'b0, 16'd0, 9'd4);
		access(64'd60000000, 1'b1, 16'd2, 9'd4);
		access(64'd10000000, 1'b0, 16'd0, 9'd4);          // older: dropped
		access(64'd70000000, 1'b0, 16'd100, 9'd0);        // zero length
		access(64'd80000000, 1'b0, 16'd65400, 9'd300);    // clamped, runs off the table
		access(64'd80000000, 1'b0, 16'd65535, 9'd1);      // same time is not older
		access(64'd80000000 + 64'd10000000 * 5000, 1'b0, 16'd0, 9'd2); // last bin
		access(64'd90000000 + 64'd10000000 * 5000, 1'b1, 16'd65535, 9'd511);
		access(64'd90000000 + 64'd10000000 * 5000, 1'b1, 16'd65470, 9'd100);
		read_bin(HIST_RAR, 12'd5);
		read_bin(HIST_RAR, 12'd4095);
		read_bin(HIST_WAR, 12'd1);
		read_bin(HIST_WAR, 12'd0);
		read_bin(HIST_WAR, 12'd4095);
		access(64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 16'hFFFF, 9'h1FF);

		divisors = '{32'd10000000, 32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd65535};
		divisors[4] = $urandom_range(32'hFFFF_FFFF, 1);
		for (int p = 0; p < 6; p++) begin
			write_divisor(divisors[p]);
			case (p / 2)
				0: begin tx_idle = 7; rx_idle = 76; end
				1: begin tx_idle = 76; rx_idle = 7; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			if (p == 5) hold_asks++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send(random_item());
		end
		req_valid <= 1'b0;

		while (sb.pending_outcomes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d results: %0d accesses, %0d dropped, %0d bin reads",
			results_seen, sb.n_access, sb.n_drop, sb.n_bin_reads);
		$display("reuse hits: %0d read-after-read, %0d write-after-read, %0d off-table runs",
			sb.n_rar, sb.n_war, sb.n_oor);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
